@@ src/dmtp_pkg.sv @@
// Shared types and constants for the DNS message token parser.
// Holds the parse phase encoding, token kind codes and the token record.
// No dependencies.
`timescale 1ns / 1ps

package dmtp_pkg;

   // Token kind codes carried on the result channel.
   localparam logic [4:0] KIND_ID        = 5'd0;
   localparam logic [4:0] KIND_FLAGS     = 5'd1;
   localparam logic [4:0] KIND_QDCOUNT   = 5'd2;
   localparam logic [4:0] KIND_ANCOUNT   = 5'd3;
   localparam logic [4:0] KIND_NSCOUNT   = 5'd4;
   localparam logic [4:0] KIND_ARCOUNT   = 5'd5;
   localparam logic [4:0] KIND_NAME_CHAR = 5'd6;
   localparam logic [4:0] KIND_DOT       = 5'd7;
   localparam logic [4:0] KIND_NAME_END  = 5'd8;
   localparam logic [4:0] KIND_QTYPE     = 5'd9;
   localparam logic [4:0] KIND_QCLASS    = 5'd10;
   localparam logic [4:0] KIND_TYPE      = 5'd11;
   localparam logic [4:0] KIND_CLASS     = 5'd12;
   localparam logic [4:0] KIND_TTL       = 5'd13;
   localparam logic [4:0] KIND_RDLENGTH  = 5'd14;
   localparam logic [4:0] KIND_RDATA     = 5'd15;
   localparam logic [4:0] KIND_NONE      = 5'd16;

   // End status codes.
   localparam logic [1:0] STATUS_BUSY      = 2'd0;
   localparam logic [1:0] STATUS_COMPLETE  = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
   localparam logic [1:0] STATUS_NAME_LONG = 2'd3;

   // Record sections.
   localparam logic [1:0] SECT_QUESTION   = 2'd0;
   localparam logic [1:0] SECT_ANSWER     = 2'd1;
   localparam logic [1:0] SECT_AUTHORITY  = 2'd2;
   localparam logic [1:0] SECT_ADDITIONAL = 2'd3;

   // Configuration register indexes and reset value.
   localparam logic REG_MAX_NAME_LENGTH = 1'b0;
   localparam logic [7:0] MAX_NAME_LENGTH_RESET = 8'd255;

   // Label separator character is implied by the dot token; its ASCII code.
   localparam logic [7:0] DOT_CHAR = 8'h2E;

   // Parse phase, one-hot.
   typedef enum logic [14:0] {
      PH_ID      = 15'b000000000000001,
      PH_FLAGS   = 15'b000000000000010,
      PH_QDCOUNT = 15'b000000000000100,
      PH_ANCOUNT = 15'b000000000001000,
      PH_NSCOUNT = 15'b000000000010000,
      PH_ARCOUNT = 15'b000000000100000,
      PH_NAME    = 15'b000000001000000,
      PH_QTYPE   = 15'b000000010000000,
      PH_QCLASS  = 15'b000000100000000,
      PH_TYPE    = 15'b000001000000000,
      PH_CLASS   = 15'b000010000000000,
      PH_TTL     = 15'b000100000000000,
      PH_RDLEN   = 15'b001000000000000,
      PH_RDATA   = 15'b010000000000000,
      PH_DONE    = 15'b100000000000000
   } phase_type;

   // One result item.
   typedef struct packed {
      logic [4:0]  kind;
      logic [31:0] value;
      logic [1:0]  section;
      logic [1:0]  status;
   } token_type;

endpackage

@@ src/dmtp_core.sv @@
// Byte-level parse state and token generation for the DNS message token parser.
// One byte is consumed per accepted item; depends on dmtp_pkg.
`timescale 1ns / 1ps

module dmtp_core
   import dmtp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   input  logic [7:0] max_name_length,
   output logic       token_have,
   output token_type  token
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  field_idx_ff, field_idx_in;
   logic [23:0] acc_ff, acc_in;
   logic [15:0] q_left_ff, q_left_in;
   logic [15:0] an_left_ff, an_left_in;
   logic [15:0] ns_left_ff, ns_left_in;
   logic [15:0] ar_left_ff, ar_left_in;
   logic [1:0]  section_ff, section_in;
   logic [7:0]  name_cnt_ff, name_cnt_in;
   logic [7:0]  label_left_ff, label_left_in;
   logic [15:0] rdata_left_ff, rdata_left_in;
   logic        discard_ff, discard_in;

   logic        do_next;
   logic        name_err;
   logic        clear;
   logic        field_done;
   logic [15:0] half_value;

   assign half_value = {acc_ff[7:0], data_byte};

   // Next state and token for the byte at the input.
   always_comb begin
      phase_in      = phase_ff;
      field_idx_in  = field_idx_ff;
      acc_in        = acc_ff;
      q_left_in     = q_left_ff;
      an_left_in    = an_left_ff;
      ns_left_in    = ns_left_ff;
      ar_left_in    = ar_left_ff;
      section_in    = section_ff;
      name_cnt_in   = name_cnt_ff;
      label_left_in = label_left_ff;
      rdata_left_in = rdata_left_ff;
      discard_in    = discard_ff;
      token.kind    = KIND_NONE;
      token.value   = 32'd0;
      token.section = SECT_QUESTION;
      token.status  = STATUS_BUSY;
      token_have    = 1'b0;
      do_next       = 1'b0;
      name_err      = 1'b0;
      clear         = 1'b0;
      field_done    = 1'b0;

      if (discard_ff) begin
         clear = last_byte;
      end else begin
         // A field of two bytes is done on its second byte, the TTL on its fourth.
         field_done = (phase_ff == PH_TTL) ? (field_idx_ff == 2'd3) : (field_idx_ff == 2'd1);

         unique case (phase_ff)
            PH_ID, PH_FLAGS, PH_QDCOUNT, PH_ANCOUNT, PH_NSCOUNT, PH_ARCOUNT: begin
               if (field_done) begin
                  token_have   = 1'b1;
                  token.value  = {16'd0, half_value};
                  field_idx_in = 2'd0;
                  acc_in       = 24'd0;
                  unique case (phase_ff)
                     PH_ID: begin
                        token.kind = KIND_ID;
                        phase_in   = PH_FLAGS;
                     end
                     PH_FLAGS: begin
                        token.kind = KIND_FLAGS;
                        phase_in   = PH_QDCOUNT;
                     end
                     PH_QDCOUNT: begin
                        token.kind = KIND_QDCOUNT;
                        q_left_in  = half_value;
                        phase_in   = PH_ANCOUNT;
                     end
                     PH_ANCOUNT: begin
                        token.kind = KIND_ANCOUNT;
                        an_left_in = half_value;
                        phase_in   = PH_NSCOUNT;
                     end
                     PH_NSCOUNT: begin
                        token.kind = KIND_NSCOUNT;
                        ns_left_in = half_value;
                        phase_in   = PH_ARCOUNT;
                     end
                     default: begin
                        token.kind = KIND_ARCOUNT;
                        ar_left_in = half_value;
                        do_next    = 1'b1;
                     end
                  endcase
               end else begin
                  field_idx_in = field_idx_ff + 2'd1;
                  acc_in       = {acc_ff[15:0], data_byte};
               end
            end
            PH_NAME: begin
               token.section = section_ff;
               if (name_cnt_ff >= max_name_length) begin
                  name_err = 1'b1;
               end else if (label_left_ff != 8'd0) begin
                  token.kind    = KIND_NAME_CHAR;
                  token.value   = {24'd0, data_byte};
                  token_have    = 1'b1;
                  label_left_in = label_left_ff - 8'd1;
                  name_cnt_in   = name_cnt_ff + 8'd1;
               end else if (data_byte == 8'd0) begin
                  token.kind  = KIND_NAME_END;
                  token_have  = 1'b1;
                  name_cnt_in = 8'd0;
                  phase_in    = (section_ff == SECT_QUESTION) ? PH_QTYPE : PH_TYPE;
               end else begin
                  // A length byte after the first label starts a new label.
                  if (name_cnt_ff != 8'd0) begin
                     token.kind = KIND_DOT;
                     token_have = 1'b1;
                  end
                  label_left_in = data_byte;
                  name_cnt_in   = name_cnt_ff + 8'd1;
               end
            end
            PH_QTYPE, PH_QCLASS, PH_TYPE, PH_CLASS, PH_TTL, PH_RDLEN: begin
               token.section = section_ff;
               if (field_done) begin
                  token_have   = 1'b1;
                  field_idx_in = 2'd0;
                  acc_in       = 24'd0;
                  token.value  = (phase_ff == PH_TTL) ? {acc_ff, data_byte}
                                                      : {16'd0, half_value};
                  unique case (phase_ff)
                     PH_QTYPE: begin
                        token.kind = KIND_QTYPE;
                        phase_in   = PH_QCLASS;
                     end
                     PH_QCLASS: begin
                        token.kind = KIND_QCLASS;
                        do_next    = 1'b1;
                     end
                     PH_TYPE: begin
                        token.kind = KIND_TYPE;
                        phase_in   = PH_CLASS;
                     end
                     PH_CLASS: begin
                        token.kind = KIND_CLASS;
                        phase_in   = PH_TTL;
                     end
                     PH_TTL: begin
                        token.kind = KIND_TTL;
                        phase_in   = PH_RDLEN;
                     end
                     default: begin
                        token.kind    = KIND_RDLENGTH;
                        rdata_left_in = half_value;
                        if (half_value != 16'd0) begin
                           phase_in = PH_RDATA;
                        end else begin
                           do_next = 1'b1;
                        end
                     end
                  endcase
               end else begin
                  field_idx_in = field_idx_ff + 2'd1;
                  acc_in       = {acc_ff[15:0], data_byte};
               end
            end
            PH_RDATA: begin
               token.section = section_ff;
               token.kind    = KIND_RDATA;
               token.value   = {24'd0, data_byte};
               token_have    = 1'b1;
               rdata_left_in = rdata_left_ff - 16'd1;
               do_next       = (rdata_left_ff == 16'd1);
            end
            default: begin
               // Bytes after the last record are ignored.
            end
         endcase

         // Move to the next record, taking sections in order.
         if (do_next) begin
            name_cnt_in   = 8'd0;
            label_left_in = 8'd0;
            field_idx_in  = 2'd0;
            acc_in        = 24'd0;
            phase_in      = PH_NAME;
            priority if (q_left_in != 16'd0) begin
               q_left_in  = q_left_in - 16'd1;
               section_in = SECT_QUESTION;
            end else if (an_left_in != 16'd0) begin
               an_left_in = an_left_in - 16'd1;
               section_in = SECT_ANSWER;
            end else if (ns_left_in != 16'd0) begin
               ns_left_in = ns_left_in - 16'd1;
               section_in = SECT_AUTHORITY;
            end else if (ar_left_in != 16'd0) begin
               ar_left_in = ar_left_in - 16'd1;
               section_in = SECT_ADDITIONAL;
            end else begin
               phase_in = PH_DONE;
            end
         end

         // Rejected name, or end of the datagram.
         if (name_err) begin
            token.kind    = KIND_NONE;
            token.value   = 32'd0;
            token.section = SECT_QUESTION;
            token.status  = STATUS_NAME_LONG;
            token_have    = 1'b1;
            discard_in    = 1'b1;
            clear         = last_byte;
         end else if (last_byte) begin
            token.status = (phase_in == PH_DONE) ? STATUS_COMPLETE : STATUS_TRUNCATED;
            if (!token_have) begin
               token.kind    = KIND_NONE;
               token.value   = 32'd0;
               token.section = SECT_QUESTION;
            end
            token_have = 1'b1;
            clear      = 1'b1;
         end
      end

      // Return to the header for the next datagram.
      if (clear) begin
         phase_in      = PH_ID;
         field_idx_in  = 2'd0;
         acc_in        = 24'd0;
         q_left_in     = 16'd0;
         an_left_in    = 16'd0;
         ns_left_in    = 16'd0;
         ar_left_in    = 16'd0;
         section_in    = SECT_QUESTION;
         name_cnt_in   = 8'd0;
         label_left_in = 8'd0;
         rdata_left_in = 16'd0;
         discard_in    = 1'b0;
      end
   end

   // Parse state advances on each accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_ID;
         field_idx_ff  <= 2'd0;
         acc_ff        <= 24'd0;
         q_left_ff     <= 16'd0;
         an_left_ff    <= 16'd0;
         ns_left_ff    <= 16'd0;
         ar_left_ff    <= 16'd0;
         section_ff    <= SECT_QUESTION;
         name_cnt_ff   <= 8'd0;
         label_left_ff <= 8'd0;
         rdata_left_ff <= 16'd0;
         discard_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         field_idx_ff  <= field_idx_in;
         acc_ff        <= acc_in;
         q_left_ff     <= q_left_in;
         an_left_ff    <= an_left_in;
         ns_left_ff    <= ns_left_in;
         ar_left_ff    <= ar_left_in;
         section_ff    <= section_in;
         name_cnt_ff   <= name_cnt_in;
         label_left_ff <= label_left_in;
         rdata_left_ff <= rdata_left_in;
         discard_ff    <= discard_in;
      end
   end

`ifndef SYNTHESIS
   // The final byte always returns the parser to the header.
   a_last_clears : assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> phase_ff == PH_ID && !discard_ff)
      else $error("final byte did not clear the parse state");

   // Nothing comes out while the rest of a datagram is dropped.
   a_discard_quiet : assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> !token_have)
      else $error("token produced while discarding");

   // A name that reaches the limit starts discarding unless the datagram ends.
   a_err_discards : assert property (@(posedge clock) disable iff (reset)
      accept && token_have && token.status == STATUS_NAME_LONG && !last_byte
      |=> discard_ff)
      else $error("rejected name did not start discarding");
`endif

endmodule

@@ src/dmtp_skid.sv @@
// Output register with a skid stage for the token channel.
// Lets the parser take a byte while a token waits; depends on dmtp_pkg.
`timescale 1ns / 1ps

module dmtp_skid
   import dmtp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  token_type in_token,
   output logic      in_ready,
   output logic      out_valid,
   input  logic      out_ready,
   output token_type out_token
);

   logic      main_valid_ff;
   logic      skid_valid_ff;
   token_type main_ff;
   token_type skid_ff;
   logic      main_free;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_token = main_ff;
   assign main_free = !main_valid_ff || out_ready;

   // Control: the skid stage fills only when the main stage is held.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (main_free) begin
         main_valid_ff <= skid_valid_ff || in_valid;
         skid_valid_ff <= 1'b0;
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      if (main_free) begin
         main_ff <= skid_valid_ff ? skid_ff : in_token;
      end else if (in_valid && !skid_valid_ff) begin
         skid_ff <= in_token;
      end
   end

`ifndef SYNTHESIS
   // The skid stage is only ever occupied behind a held main stage.
   a_skid_behind_main : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid stage full with main stage empty");

   // A held skid token stays until the main stage moves.
   a_skid_holds : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !out_ready |=> skid_valid_ff && $stable(skid_ff))
      else $error("skid token lost while stalled");

   // No new token is offered while the skid stage is full.
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !in_ready)
      else $error("input taken with skid stage full");
`endif

endmodule

@@ src/dns_message_token_parser.sv @@
// Top level of the DNS message token parser: stream ports, register port.
// Instantiates dmtp_core and dmtp_skid; depends on dmtp_pkg.
`timescale 1ns / 1ps

// Usage:
// A datagram enters on the req_ channel one byte per item, req_tlast set on
// its final byte. Tokens leave on the rsp_ channel: the kind in rsp_tuser,
// the value, record section and end status in rsp_tdata. A byte yields at
// most one token; a name's first length byte, early field bytes and bytes
// after the last record yield none. The final byte yields one carrying the
// status unless the datagram is dropped after a rejected name. The block
// takes one byte per cycle while req_tready is high. When the receiver
// stalls, one token waits in the output register and one more in a skid
// stage; req_tready drops only once that skid stage is full. Reset clears
// the parse state, both output stages and sets max_name_length to 255. The
// register is to be written over the csr_ port only while no datagram is in
// flight, which the block does not enforce; it is kept between datagrams.
module dns_message_token_parser
   import dmtp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input byte stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   // Token stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] token_value, [33:32] record_section,
                                    // [35:34] end_status, [39:36] zero
   output logic [4:0]  rsp_tuser,   // [4:0] token_kind
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic       max_len_write;
   logic [7:0] max_name_length_ff;
   logic       accept;
   logic       token_have;
   token_type  token;
   token_type  out_token;

   assign accept = req_tvalid && req_tready;

   // Register write and read.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MAX_NAME_LENGTH) ? {24'd0, max_name_length_ff}
                                                            : 32'd0;
   assign max_len_write = csr_psel && csr_penable && csr_pwrite && csr_pready
                          && (csr_paddr[2] == REG_MAX_NAME_LENGTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_name_length_ff <= MAX_NAME_LENGTH_RESET;
      end else if (max_len_write) begin
         max_name_length_ff <= csr_pwdata[7:0];
      end
   end

   dmtp_core u_core (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .data_byte       (req_tdata),
      .last_byte       (req_tlast),
      .max_name_length (max_name_length_ff),
      .token_have      (token_have),
      .token           (token)
   );

   dmtp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept && token_have),
      .in_token  (token),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_token (out_token)
   );

   // Pack the token onto the result ports.
   assign rsp_tuser = out_token.kind;
   assign rsp_tdata = {4'd0, out_token.status, out_token.section, out_token.value};

`ifndef SYNTHESIS
   // Reset leaves no token on the output.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("token visible after reset");

   // Only a rejected name or a final byte carries a nonzero status.
   a_status_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_token.status == STATUS_NAME_LONG |-> out_token.kind == KIND_NONE)
      else $error("name error status on a data token");

   // A token of kind none never carries a section.
   a_none_section : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_token.kind == KIND_NONE |-> out_token.section == SECT_QUESTION)
      else $error("kind none with a section");
`endif

endmodule
